### src/izh_pkg.sv
// ----------------------------------------------------------------------------
// Izhikevich neuron step: shared package
// Fixed-point constants and arithmetic helpers for the Q16.16 neuron pipeline.
// ----------------------------------------------------------------------------
package izh_pkg;

   localparam int unsigned FxWidth       = 32;
   localparam int unsigned SubstepCount  = 4;

   localparam logic signed [31:0] FxK004 = 32'sd2621;
   localparam logic signed [31:0] FxK5   = 32'sd327680;
   localparam logic signed [31:0] FxK140 = 32'sd9175040;
   localparam logic signed [31:0] FxK30  = 32'sd1966080;
   localparam logic signed [31:0] FxMax  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] FxMin  = 32'sh8000_0000;

   typedef logic signed [31:0] fx_type;

   // Clamp a 34-bit signed sum to the Q16.16 range.
   function automatic fx_type sat34(input logic signed [33:0] x);
      fx_type r;
      if (x > 34'(signed'(FxMax))) begin
         r = FxMax;
      end else if (x < 34'(signed'(FxMin))) begin
         r = FxMin;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   // Round a full 64-bit product back to Q16.16 with saturation.
   function automatic fx_type round_prod(input logic signed [63:0] p);
      logic signed [64:0] t;
      logic signed [48:0] s;
      fx_type r;
      t = 65'(p) + 65'sd32768;
      s = t[64:16];
      if (s > 49'(signed'(FxMax))) begin
         r = FxMax;
      end else if (s < 49'(signed'(FxMin))) begin
         r = FxMin;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   function automatic fx_type add2(input fx_type x, input fx_type y);
      return sat34(34'(x) + 34'(y));
   endfunction

   function automatic fx_type sub2(input fx_type x, input fx_type y);
      return sat34(34'(x) - 34'(y));
   endfunction

   typedef struct packed {
      fx_type a;
      fx_type b;
      fx_type c;
      fx_type d;
      fx_type u;
      fx_type v;
      fx_type cur;
      logic   forced;
      logic   fired;
   } nrn_type;

endpackage

### src/izh_substep.sv
// ----------------------------------------------------------------------------
// Izhikevich neuron step: one Euler substep
// Six register stages, each holding one multiplication and its rounding.
// ----------------------------------------------------------------------------
module izh_substep #(
   parameter int unsigned SUBSTEP_COUNT = izh_pkg::SubstepCount
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  izh_pkg::nrn_type in_data,
   output logic             out_valid,
   output izh_pkg::nrn_type out_data
);

   localparam logic signed [31:0] FxStep =
      32'((65536 + SUBSTEP_COUNT / 2) / SUBSTEP_COUNT);
   localparam int unsigned Stages = 6;

   logic [Stages-1:0]         vld_ff;
   logic [Stages-1:0]         vld_in;
   izh_pkg::nrn_type          nrn_ff [Stages];
   izh_pkg::nrn_type          nrn_in [Stages];
   izh_pkg::fx_type           tmp_ff [Stages];
   izh_pkg::fx_type           tmp_in [Stages];

   always_comb begin
      vld_in = {vld_ff[Stages-2:0], in_valid};
      nrn_in[0] = in_data;
      for (int i = 1; i < Stages; i++) begin
         nrn_in[i] = nrn_ff[i-1];
         tmp_in[i] = tmp_ff[i-1];
      end
      // Stage 0: p = 0.04 v + 5.
      tmp_in[0] = izh_pkg::add2(
         izh_pkg::round_prod(64'(izh_pkg::FxK004) * 64'(in_data.v)), izh_pkg::FxK5);
      // Stage 1: q = p v + 140 - u + I.
      tmp_in[1] = izh_pkg::sat34(
         34'(izh_pkg::round_prod(64'(tmp_ff[0]) * 64'(nrn_ff[0].v)))
         + 34'(izh_pkg::FxK140) - 34'(nrn_ff[0].u) + 34'(nrn_ff[0].cur));
      // Stage 2: v += h q.
      nrn_in[2].v = izh_pkg::add2(nrn_ff[1].v,
         izh_pkg::round_prod(64'(FxStep) * 64'(tmp_ff[1])));
      // Stage 3: r = b v - u.
      tmp_in[3] = izh_pkg::sub2(
         izh_pkg::round_prod(64'(nrn_ff[2].b) * 64'(nrn_ff[2].v)), nrn_ff[2].u);
      // Stage 4: a r.
      tmp_in[4] = izh_pkg::round_prod(64'(nrn_ff[3].a) * 64'(tmp_ff[3]));
      // Stage 5: u += h (a r), then the threshold check.
      nrn_in[5].u = izh_pkg::add2(nrn_ff[4].u,
         izh_pkg::round_prod(64'(FxStep) * 64'(tmp_ff[4])));
      nrn_in[5].fired = nrn_ff[4].v >= izh_pkg::FxK30;
      // A neuron that has already fired passes through untouched.
      if (nrn_ff[1].fired) begin
         nrn_in[2].v = nrn_ff[1].v;
      end
      if (nrn_ff[4].fired) begin
         nrn_in[5].u     = nrn_ff[4].u;
         nrn_in[5].fired = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
      if (advance) begin
         for (int i = 0; i < Stages; i++) begin
            nrn_ff[i] <= nrn_in[i];
            tmp_ff[i] <= tmp_in[i];
         end
      end
   end

   assign out_valid = vld_ff[Stages-1];
   assign out_data  = nrn_ff[Stages-1];

endmodule

### src/izh_front.sv
// ----------------------------------------------------------------------------
// Izhikevich neuron step: noise injection
// Two stages: sigma times the sample, then the saturated add to the current.
// ----------------------------------------------------------------------------
module izh_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  izh_pkg::nrn_type in_data,
   input  izh_pkg::fx_type  sigma,
   input  izh_pkg::fx_type  sample,
   output logic             out_valid,
   output izh_pkg::nrn_type out_data
);

   logic             vld0_ff, vld1_ff;
   izh_pkg::nrn_type nrn0_ff, nrn1_ff, nrn1_in;
   izh_pkg::fx_type  noise_ff, noise_in;
   logic             use_ff;

   always_comb begin
      noise_in = izh_pkg::round_prod(64'(sigma) * 64'(sample));
      nrn1_in  = nrn0_ff;
      if (use_ff) begin
         nrn1_in.cur = izh_pkg::add2(nrn0_ff.cur, noise_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
      end else if (advance) begin
         vld0_ff <= in_valid;
         vld1_ff <= vld0_ff;
      end
      if (advance) begin
         nrn0_ff  <= in_data;
         noise_ff <= noise_in;
         use_ff   <= sigma != '0;
         nrn1_ff  <= nrn1_in;
      end
   end

   assign out_valid = vld1_ff;
   assign out_data  = nrn1_ff;

endmodule

### src/izhikevich_neuron_step.sv
// ----------------------------------------------------------------------------
// Izhikevich neuron step: top level
// Advances one neuron by one millisecond in a fully unrolled pipeline.
// ----------------------------------------------------------------------------
// One neuron word is accepted every cycle. The pipeline holds two noise
// stages, six multiplier stages per Euler substep, and a spike-reset stage
// feeding the output register. The whole pipeline stalls together when the
// result side holds back; ready is low only while a finished word waits at
// the output.
module izhikevich_neuron_step #(
   parameter int unsigned SUBSTEP_COUNT = izh_pkg::SubstepCount
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_recovery_rate,
   input  logic [31:0] req_recovery_sensitivity,
   input  logic [31:0] req_reset_potential,
   input  logic [31:0] req_recovery_jump,
   input  logic [31:0] req_recovery_in,
   input  logic [31:0] req_potential_in,
   input  logic [31:0] req_noise_gain,
   input  logic [31:0] req_noise_sample,
   input  logic [31:0] req_input_current,
   input  logic        req_force_fire,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_recovery_out,
   output logic [31:0] rsp_potential_out,
   output logic        rsp_spiked
);

   logic             advance;
   logic             vld [SUBSTEP_COUNT+1];
   izh_pkg::nrn_type nrn [SUBSTEP_COUNT+1];
   izh_pkg::nrn_type req_nrn;
   logic             rsp_valid_ff;
   izh_pkg::fx_type  u_ff, v_ff, u_in, v_in;
   logic             spk_ff, spk_in;

   // The pipeline moves whenever the output register is empty or being read.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      req_nrn.a      = req_recovery_rate;
      req_nrn.b      = req_recovery_sensitivity;
      req_nrn.c      = req_reset_potential;
      req_nrn.d      = req_recovery_jump;
      req_nrn.u      = req_recovery_in;
      req_nrn.v      = req_potential_in;
      req_nrn.cur    = req_input_current;
      req_nrn.forced = req_force_fire;
      req_nrn.fired  = 1'b0;
   end

   izh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_nrn),
      .sigma     (req_noise_gain),
      .sample    (req_noise_sample),
      .out_valid (vld[0]),
      .out_data  (nrn[0])
   );

   for (genvar k = 0; k < SUBSTEP_COUNT; k++) begin : g_sub
      izh_substep #(.SUBSTEP_COUNT(SUBSTEP_COUNT)) u_sub (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (vld[k]),
         .in_data   (nrn[k]),
         .out_valid (vld[k+1]),
         .out_data  (nrn[k+1])
      );
   end

   always_comb begin
      spk_in = nrn[SUBSTEP_COUNT].fired || nrn[SUBSTEP_COUNT].forced;
      u_in   = nrn[SUBSTEP_COUNT].u;
      v_in   = nrn[SUBSTEP_COUNT].v;
      if (spk_in) begin
         v_in = nrn[SUBSTEP_COUNT].c;
         u_in = izh_pkg::add2(nrn[SUBSTEP_COUNT].u, nrn[SUBSTEP_COUNT].d);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld[SUBSTEP_COUNT];
      end
      if (advance) begin
         u_ff   <= u_in;
         v_ff   <= v_in;
         spk_ff <= spk_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_recovery_out  = u_ff;
   assign rsp_potential_out = v_ff;
   assign rsp_spiked        = spk_ff;

endmodule

### tb/sv/izh_step_checker.sv
// ----------------------------------------------------------------------------
// Izhikevich neuron step: result checker
// Watches both channels, predicts each result word in Q16.16 arithmetic and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module izh_step_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_recovery_rate,
   input  logic [31:0] req_recovery_sensitivity,
   input  logic [31:0] req_reset_potential,
   input  logic [31:0] req_recovery_jump,
   input  logic [31:0] req_recovery_in,
   input  logic [31:0] req_potential_in,
   input  logic [31:0] req_noise_gain,
   input  logic [31:0] req_noise_sample,
   input  logic [31:0] req_input_current,
   input  logic        req_force_fire,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_recovery_out,
   input  logic [31:0] rsp_potential_out,
   input  logic        rsp_spiked,
   output int          error_count,
   output int          pending_count,
   output int          spike_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] recovery;
      logic [31:0] potential;
      logic        spiked;
   } neuron_result_type;

   neuron_result_type next_state_q[$];

   localparam longint StepSize =
      (65536 + izh_pkg::SubstepCount / 2) / izh_pkg::SubstepCount;

   function automatic longint clamp32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // Exact product, round to nearest with ties upward, then clamp.
   function automatic longint qmul(input longint x, input longint y);
      longint p;
      p = x * y + 32768;
      return clamp32(p >>> 16);
   endfunction

   function automatic neuron_result_type advance_neuron(
      input logic [31:0] ra, rb, rc, rd, ru, rv, rs, rn, ri, input logic ff);
      longint a, b, c, d, u, v, sg, cur, p, q, r;
      logic fired;
      neuron_result_type res;
      a = longint'(signed'(ra)); b = longint'(signed'(rb));
      c = longint'(signed'(rc)); d = longint'(signed'(rd));
      u = longint'(signed'(ru)); v = longint'(signed'(rv));
      sg = longint'(signed'(rs)); cur = longint'(signed'(ri));
      fired = 1'b0;
      if (sg != 0) cur = clamp32(cur + qmul(sg, longint'(signed'(rn))));
      for (int k = 0; k < izh_pkg::SubstepCount; k++) begin
         if (!fired) begin
            p = clamp32(qmul(2621, v) + 327680);
            q = clamp32(qmul(p, v) + 9175040 - u + cur);
            v = clamp32(v + qmul(StepSize, q));
            r = clamp32(qmul(b, v) - u);
            u = clamp32(u + qmul(StepSize, qmul(a, r)));
            fired = (v >= 1966080);
         end
      end
      fired = fired | ff;
      if (fired) begin
         v = c;
         u = clamp32(u + d);
      end
      res.recovery = u[31:0];
      res.potential = v[31:0];
      res.spiked = fired;
      return res;
   endfunction

   always @(posedge clock) begin
      neuron_result_type want;
      if (reset) begin
         error_count <= 0;
         spike_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            next_state_q = {next_state_q, advance_neuron(req_recovery_rate,
               req_recovery_sensitivity, req_reset_potential, req_recovery_jump,
               req_recovery_in, req_potential_in, req_noise_gain, req_noise_sample,
               req_input_current, req_force_fire)};
         end
         if (rsp_valid && rsp_ready) begin
            if (next_state_q.size() == 0) begin
               if (error_count < 10) $display("ERROR: result word with none expected");
               error_count <= error_count + 1;
            end else begin
               want = next_state_q.pop_front();
               if (rsp_spiked) spike_count <= spike_count + 1;
               if (want.recovery !== rsp_recovery_out || want.potential !== rsp_potential_out
                   || want.spiked !== rsp_spiked) begin
                  if (error_count < 10)
                     $display("ERROR: u exp %h got %h, v exp %h got %h, spk exp %b got %b",
                        want.recovery, rsp_recovery_out, want.potential, rsp_potential_out,
                        want.spiked, rsp_spiked);
                  error_count <= error_count + 1;
               end
            end
         end
         pending_count <= next_state_q.size();
      end
   end
endmodule

### tb/sv/tb_izhikevich_neuron_step.sv
// ----------------------------------------------------------------------------
// Izhikevich neuron step: testbench top
// Drives directed and random neuron words with bursty sending and a stalling
// receiver; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_izhikevich_neuron_step;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 5000;
   localparam int RandomWords = 1600;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_ready;
   logic [31:0] req_recovery_rate = '0, req_recovery_sensitivity = '0;
   logic [31:0] req_reset_potential = '0, req_recovery_jump = '0;
   logic [31:0] req_recovery_in = '0, req_potential_in = '0;
   logic [31:0] req_noise_gain = '0, req_noise_sample = '0, req_input_current = '0;
   logic req_force_fire = 1'b0;
   logic rsp_valid, rsp_ready = 1'b0;
   logic [31:0] rsp_recovery_out, rsp_potential_out;
   logic rsp_spiked;
   int error_count, pending_count, spike_count;
   int idle_cycles = 0;
   int words_sent = 0;
   logic [31:0] word_fields[9];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   izhikevich_neuron_step u_top (.*);

   izh_step_checker u_checker (.*);

   // Receiver: its own stall pattern, with quiet stretches of full readiness.
   always @(posedge clock) begin
      int phase;
      phase = (phase + 1) % 400;
      if (phase < 80) rsp_ready <= 1'b1;
      else if (phase < 200) rsp_ready <= ($urandom_range(0, 3) != 0);
      else rsp_ready <= ($urandom_range(0, 1) == 1);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Watchdog expired with %0d results outstanding", pending_count);
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [31:0] pick_value(input int kind);
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom;
         default: return 32'(signed'($urandom_range(0, 2 * kind)) - kind);
      endcase
   endfunction

   // Holds a word on the channel until the block takes it.
   task automatic send_word(input logic [31:0] f[9], input logic ff);
      req_valid <= 1'b1;
      req_recovery_rate <= f[0]; req_recovery_sensitivity <= f[1];
      req_reset_potential <= f[2]; req_recovery_jump <= f[3];
      req_recovery_in <= f[4]; req_potential_in <= f[5];
      req_noise_gain <= f[6]; req_noise_sample <= f[7];
      req_input_current <= f[8]; req_force_fire <= ff;
      do @(posedge clock); while (!(req_valid && req_ready));
      words_sent++;
   endtask

   task automatic pause_sender(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Typical neuron: a about 0.02 to 0.1, b 0.2 to 0.28, c -65 to -50, d 0 to 8, small state and current.
   task automatic plausible_neuron(output logic [31:0] f[9]);
      f[0] = 32'(1311 + int'($urandom_range(0, 5000)));
      f[1] = 32'(13107 + int'($urandom_range(0, 5000)));
      f[2] = 32'(-65 * 65536 + int'($urandom_range(0, 15 * 65536)));
      f[3] = 32'(int'($urandom_range(0, 8 * 65536)));
      f[4] = 32'(-20 * 65536 + int'($urandom_range(0, 20 * 65536)));
      f[5] = 32'(-80 * 65536 + int'($urandom_range(0, 115 * 65536)));
      f[6] = ($urandom_range(0, 2) == 0) ? 32'h0 : 32'($urandom_range(0, 5 * 65536));
      f[7] = 32'(int'($urandom_range(0, 6 * 65536)) - 3 * 65536);
      f[8] = 32'(int'($urandom_range(0, 40 * 65536)) - 5 * 65536);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, forced spikes, saturation, noise on and off.
      for (int d = 0; d < 20; d++) begin
         for (int i = 0; i < 9; i++)
            word_fields[i] = (d < 2) ? (d == 0 ? 32'h7FFF_FFFF : 32'h8000_0000)
                           : (d < 4) ? (d == 2 ? 32'h0 : 32'hFFFF_FFFF) : pick_value(1 << 22);
         if (d >= 4 && d < 12) plausible_neuron(word_fields);
         if (d == 6) word_fields[5] = 32'(30 * 65536);
         if (d == 7) word_fields[5] = 32'(30 * 65536 - 1);
         send_word(word_fields, d[0]);
      end
      pause_sender(1);
      wait (pending_count == 0);

      while (words_sent < 20 + RandomWords) begin
         repeat ($urandom_range(1, 30)) begin
            if ($urandom_range(0, 9) < 8) plausible_neuron(word_fields);
            else for (int i = 0; i < 9; i++) word_fields[i] = pick_value(1 << 24);
            send_word(word_fields, ($urandom_range(0, 7) == 0));
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
         if ($urandom_range(0, 40) == 0) begin
            pause_sender(1);
            wait (pending_count == 0);
         end
      end
      pause_sender(1);
      wait (pending_count == 0);
      repeat (40) @(posedge clock);

      $display("Sent %0d neuron words, %0d spikes seen, directed extremes and random states.",
         words_sent, spike_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

### izhikevich_neuron_step.f
src/izh_pkg.sv
src/izh_substep.sv
src/izh_front.sv
src/izhikevich_neuron_step.sv
tb/sv/izh_step_checker.sv
tb/sv/tb_izhikevich_neuron_step.sv
